>>> hdl/dq_pkg.sv
package dq_pkg;

    // default ring depth
    localparam int DEPTH_DEFAULT = 16;

    // field widths
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 5;
    localparam int ERR_W    = 2;

    // stream word widths, padded to whole bytes
    localparam int IN_W  = 72;
    localparam int OUT_W = 136;

    // action codes on the input stream
    localparam logic [ACTION_W-1:0] ACT_ADD_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REVERSE   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd5;

    // error codes on the output stream
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // internal operations, ends already resolved to physical ring ends
    typedef enum logic [1:0] {
        OP_NOP,
        OP_PUSH,
        OP_POP
    } t_op;

    // command word handed from the front end to the executor
    typedef struct packed {
        t_op                op;
        logic               phys_first;
        logic               rev;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    // command queue depth
    localparam int Q_DEPTH = 2;

endpackage

>>> hdl/double_ended_queue.sv
// Bounded double-ended queue of DEPTH 64-bit words in a ring buffer. Each input
// word is one action (add front/back, remove front/back, reverse, query) and
// yields exactly one output word with the front and back values, the empty
// flag, the count and an error code; removal from an empty deque or addition
// to a full one is flagged and changes nothing. Reverse only flips an
// orientation flag. The front end accepts and classifies actions into a
// two-entry command queue, so input is taken while a result waits. The
// executor takes each action through three steps (pointer update and write,
// a registered read of both ends of the store, result load) and takes no new
// action until the last result is loaded; loading waits on a stalled output.
// The entry store needs no clearing after reset.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [dq_pkg::IN_W-1:0]    i_s_tdata,   // action[2:0], value[66:3], zero pad
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // front_value[63:0], back_value[127:64], is_empty[128],
    // item_count[133:129], error_code[135:134]
    output logic [dq_pkg::OUT_W-1:0]   o_m_tdata
);

    logic          q_full;
    logic          q_push;
    dq_pkg::t_cmd  q_in_cmd;
    logic          q_pop;
    logic          q_valid;
    dq_pkg::t_cmd  q_out_cmd;

    dq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    dq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_cmd_pop   (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

>>> hdl/dq_front.sv
module dq_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [dq_pkg::IN_W-1:0]    i_s_tdata,   // action[2:0], value[66:3], zero pad
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output dq_pkg::t_cmd               o_q_cmd
);

    logic                          r_rev;
    logic                          n_rev;
    logic                          accept;
    logic [dq_pkg::ACTION_W-1:0]   action;

    assign action     = i_s_tdata[dq_pkg::ACTION_W-1:0];
    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_q_push   = accept;

    // classify the action, map logical ends onto physical ring ends
    always_comb begin
        n_rev                = r_rev;
        o_q_cmd.op           = dq_pkg::OP_NOP;
        o_q_cmd.phys_first   = 1'b0;
        o_q_cmd.value        = i_s_tdata[dq_pkg::ACTION_W +: dq_pkg::VALUE_W];
        unique case (action)
            dq_pkg::ACT_ADD_FRONT: begin
                o_q_cmd.op         = dq_pkg::OP_PUSH;
                o_q_cmd.phys_first = !r_rev;
            end
            dq_pkg::ACT_ADD_BACK: begin
                o_q_cmd.op         = dq_pkg::OP_PUSH;
                o_q_cmd.phys_first = r_rev;
            end
            dq_pkg::ACT_REM_FRONT: begin
                o_q_cmd.op         = dq_pkg::OP_POP;
                o_q_cmd.phys_first = !r_rev;
            end
            dq_pkg::ACT_REM_BACK: begin
                o_q_cmd.op         = dq_pkg::OP_POP;
                o_q_cmd.phys_first = r_rev;
            end
            dq_pkg::ACT_REVERSE: begin
                n_rev = !r_rev;
            end
            default: begin
                // query and unused codes: report only
            end
        endcase
        o_q_cmd.rev = n_rev;
    end

    // orientation flag lives here, the executor gets it with each command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= 1'b0;
        end else if (accept) begin
            r_rev <= n_rev;
        end
    end

endmodule

>>> hdl/dq_fifo.sv
module dq_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dq_pkg::t_cmd  i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dq_pkg::t_cmd  o_cmd
);

    localparam int PW = (dq_pkg::Q_DEPTH > 1) ? $clog2(dq_pkg::Q_DEPTH) : 1;
    localparam int FW = $clog2(dq_pkg::Q_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(dq_pkg::Q_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(dq_pkg::Q_DEPTH);

    dq_pkg::t_cmd  r_slot [dq_pkg::Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [FW-1:0] r_fill;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_fill == FULL_FILL);
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

endmodule

>>> hdl/dq_back.sv
module dq_back #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  dq_pkg::t_cmd               i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [dq_pkg::OUT_W-1:0]   o_m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [dq_pkg::VALUE_W-1:0] r_mem [DEPTH];

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [AW-1:0]              r_head;
    logic [AW-1:0]              n_head;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [dq_pkg::ERR_W-1:0]   r_err;
    logic [dq_pkg::ERR_W-1:0]   n_err;
    logic                       r_rev;
    logic [dq_pkg::VALUE_W-1:0] r_rd_first;
    logic [dq_pkg::VALUE_W-1:0] r_rd_last;
    logic                       r_out_valid;
    logic [dq_pkg::OUT_W-1:0]   r_out_data;

    logic                       take;
    logic                       load;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [CW:0]                sum_tail;
    logic [CW:0]                sum_last;
    logic [CW:0]                tail_mod;
    logic [CW:0]                last_mod;
    logic [AW-1:0]              head_dec;
    logic [AW-1:0]              head_inc;
    logic                       empty;
    logic [CW+4:0]              cnt_ext;
    logic [dq_pkg::VALUE_W-1:0] first_val;
    logic [dq_pkg::VALUE_W-1:0] last_val;

    assign take      = (r_state == S_IDLE) && i_cmd_valid;
    assign load      = (r_state == S_LOAD) && (!r_out_valid || i_m_tready);
    assign o_cmd_pop = take;

    // ring index arithmetic, sums stay below twice the depth
    assign sum_tail = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign sum_last = sum_tail - (CW + 1)'(1);
    assign tail_mod = (sum_tail >= DEPTH_W) ? sum_tail - DEPTH_W : sum_tail;
    assign last_mod = (sum_last >= DEPTH_W) ? sum_last - DEPTH_W : sum_last;
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);

    // execute one command: pointer update and at most one write
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_err   = dq_pkg::ERR_NONE;
        wr_en   = 1'b0;
        wr_addr = tail_mod[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_READ;
                    case (i_cmd.op)
                        dq_pkg::OP_PUSH: begin
                            if (r_count == FULL_CNT) begin
                                n_err = dq_pkg::ERR_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_cmd.phys_first) begin
                                    n_head  = head_dec;
                                    wr_addr = head_dec;
                                end
                            end
                        end
                        dq_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_err = dq_pkg::ERR_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (i_cmd.phys_first) begin
                                    n_head = head_inc;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_first <= r_mem[r_head];
            r_rd_last  <= r_mem[last_mod[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // per-command status
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_err <= n_err;
            r_rev <= i_cmd.rev;
        end
    end

    // result word, front and back swapped when reversed
    assign empty     = (r_count == '0);
    assign cnt_ext   = (CW + 5)'(r_count);
    assign first_val = empty ? '0 : r_rd_first;
    assign last_val  = empty ? '0 : r_rd_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= {r_err, cnt_ext[4:0], empty,
                           r_rev ? first_val : last_val,
                           r_rev ? last_val : first_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // count never exceeds the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FULL_CNT))
        else $error("entry count above depth");

    // a flagged command leaves the ring untouched
    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && n_err != dq_pkg::ERR_NONE) |=> ($stable(r_count) && $stable(r_head)))
        else $error("ring changed on error");

    // a good push grows the count by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op == dq_pkg::OP_PUSH && n_err == dq_pkg::ERR_NONE)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow count");

    // a result is only loaded after a read cycle
    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_LOAD))
        else $error("read not followed by load");

endmodule
